[rtl/rqlh_pkg.sv]
// ----------------------------------------------------------------------------
// rqlh_pkg
// Shared types and constants of the run-queue latency histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rqlh_pkg;

    localparam int PID_SLOTS_DEF  = 1024;
    localparam int HIST_SLOTS_DEF = 1024;

    localparam int PID_W   = 22;
    localparam int TIME_W  = 64;
    localparam int GROUP_W = 64;
    localparam int BIN_W   = 6;
    localparam int COUNT_W = 64;

    localparam logic [1:0] REQ_WAKEUP = 2'd0;
    localparam logic [1:0] REQ_SWITCH = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_PIDFULL  = 2'd2;
    localparam logic [1:0] ST_HISTFULL = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_P_RD,
        S_P_CK,
        S_N_RD,
        S_N_CK,
        S_LOG,
        S_H_RD,
        S_H_CK,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

[rtl/run_queue_latency_histogram_unit.sv]
// ----------------------------------------------------------------------------
// run_queue_latency_histogram_unit
// Per-cgroup log2 histogram of run-queue wait, with pid and counter stores.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one request item: wakeup, context
// switch or counter read. Output channel (out_valid/out_stall) returns exactly
// one result item (status, bucket, count) per request.
// Both stores are searched linearly, each through its own registered-read RAM
// port, so the time a request takes grows with table depth.
// A search stops early on a key match. One request is in flight at a time;
// in_stall is high from acceptance until the result is handed to the output
// register, which holds one finished item while the next request is taken.
// After reset, a clearing pass over max(PID_SLOTS, HIST_SLOTS) slots zeroes
// the valid bits of both stores; in_stall stays high during it.
// When the receiver stalls, the result holds in the output register, and a
// later result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module run_queue_latency_histogram_unit #(
    parameter int PID_SLOTS  = rqlh_pkg::PID_SLOTS_DEF,
    parameter int HIST_SLOTS = rqlh_pkg::HIST_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    req_type,
    input  wire logic [rqlh_pkg::PID_W-1:0]    event_pid,
    input  wire logic                          prev_still_runnable,
    input  wire logic [rqlh_pkg::PID_W-1:0]    next_pid,
    input  wire logic [rqlh_pkg::GROUP_W-1:0]  group_id,
    input  wire logic [rqlh_pkg::BIN_W-1:0]    read_bucket,
    input  wire logic [rqlh_pkg::TIME_W-1:0]   timestamp,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         status,
    output logic [rqlh_pkg::BIN_W-1:0]         bucket,
    output logic [rqlh_pkg::COUNT_W-1:0]       count
);

    import rqlh_pkg::*;

    localparam int PAW    = $clog2(PID_SLOTS);
    localparam int HAW    = $clog2(HIST_SLOTS);
    localparam int IW     = ((PAW > HAW) ? PAW : HAW) + 1;
    localparam int MAXS   = (PID_SLOTS > HIST_SLOTS) ? PID_SLOTS : HIST_SLOTS;
    localparam int PWORD  = 1 + PID_W + TIME_W;
    localparam int HWORD  = 1 + GROUP_W + BIN_W + COUNT_W;

    localparam logic [IW-1:0] P_LAST   = IW'(PID_SLOTS - 1);
    localparam logic [IW-1:0] H_LAST   = IW'(HIST_SLOTS - 1);
    localparam logic [IW-1:0] CLR_LAST = IW'(MAXS - 1);
    localparam logic [IW-1:0] P_DEPTH  = IW'(PID_SLOTS);
    localparam logic [IW-1:0] H_DEPTH  = IW'(HIST_SLOTS);

    state_t state_reg, state_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               free_reg, free_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic [1:0]         req_reg, req_next;
    logic [PID_W-1:0]   epid_reg, epid_next;
    logic [PID_W-1:0]   npid_reg, npid_next;
    logic [GROUP_W-1:0] grp_reg, grp_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [TIME_W-1:0]  wait_reg, wait_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [1:0]         st_reg, st_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_st_reg, out_st_next;
    logic [BIN_W-1:0]   out_bin_reg, out_bin_next;
    logic [COUNT_W-1:0] out_cnt_reg, out_cnt_next;

    logic             p_we;
    logic [PAW-1:0]   p_waddr;
    logic [PWORD-1:0] p_wdata;
    logic [PWORD-1:0] p_rdata;
    logic             h_we;
    logic [HAW-1:0]   h_waddr;
    logic [HWORD-1:0] h_wdata;
    logic [HWORD-1:0] h_rdata;

    logic               p_v;
    logic [PID_W-1:0]   p_key;
    logic [TIME_W-1:0]  p_time;
    logic               h_v;
    logic [GROUP_W-1:0] h_grp;
    logic [BIN_W-1:0]   h_bin;
    logic [COUNT_W-1:0] h_cnt;
    logic [IW-1:0]      free_at;
    logic               free_any;

    assign p_v    = p_rdata[PWORD-1];
    assign p_key  = p_rdata[PWORD-2 -: PID_W];
    assign p_time = p_rdata[TIME_W-1:0];
    assign h_v    = h_rdata[HWORD-1];
    assign h_grp  = h_rdata[HWORD-2 -: GROUP_W];
    assign h_bin  = h_rdata[COUNT_W +: BIN_W];
    assign h_cnt  = h_rdata[COUNT_W-1:0];

    rqlh_ram #(.WIDTH(PWORD), .DEPTH(PID_SLOTS)) u_pid_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (idx_reg[PAW-1:0]),
        .rdata (p_rdata)
    );

    rqlh_ram #(.WIDTH(HWORD), .DEPTH(HIST_SLOTS)) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (idx_reg[HAW-1:0]),
        .rdata (h_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_st_reg;
    assign bucket    = out_bin_reg;
    assign count     = out_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        req_reg      <= req_next;
        epid_reg     <= epid_next;
        npid_reg     <= npid_next;
        grp_reg      <= grp_next;
        now_reg      <= now_next;
        wait_reg     <= wait_next;
        bin_reg      <= bin_next;
        st_reg       <= st_next;
        cnt_reg      <= cnt_next;
        out_st_reg   <= out_st_next;
        out_bin_reg  <= out_bin_next;
        out_cnt_reg  <= out_cnt_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        req_next       = req_reg;
        epid_next      = epid_reg;
        npid_next      = npid_reg;
        grp_next       = grp_reg;
        now_next       = now_reg;
        wait_next      = wait_reg;
        bin_next       = bin_reg;
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_st_next    = out_st_reg;
        out_bin_next   = out_bin_reg;
        out_cnt_next   = out_cnt_reg;
        p_we           = 1'b0;
        p_waddr        = idx_reg[PAW-1:0];
        p_wdata        = '0;
        h_we           = 1'b0;
        h_waddr        = idx_reg[HAW-1:0];
        h_wdata        = '0;
        free_any       = free_reg || !p_v;
        free_at        = free_reg ? free_idx_reg : idx_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                p_we     = (idx_reg < P_DEPTH);
                h_we     = (idx_reg < H_DEPTH);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CLR_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = req_type;
                    epid_next     = event_pid;
                    npid_next     = next_pid;
                    grp_next      = group_id;
                    now_next      = timestamp;
                    bin_next      = '0;
                    cnt_next      = '0;
                    st_next       = ST_NONE;
                    idx_next      = '0;
                    free_next     = 1'b0;
                    case (req_type)
                        REQ_WAKEUP:
                        begin
                            state_next = (event_pid != '0) ? S_P_RD : S_RESP;
                        end
                        REQ_SWITCH:
                        begin
                            if (prev_still_runnable && event_pid != '0)
                            begin
                                state_next = S_P_RD;
                            end
                            else if (next_pid != '0)
                            begin
                                state_next = S_N_RD;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        REQ_READ:
                        begin
                            bin_next   = read_bucket;
                            state_next = S_H_RD;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_P_RD:
            begin
                state_next = S_P_CK;
            end

            S_P_CK:
            begin
                if ((p_v && p_key == epid_reg) || (idx_reg == P_LAST && free_any))
                begin
                    // store or overwrite; a switch then moves on to a nonzero incoming pid
                    p_we     = 1'b1;
                    p_waddr  = (p_v && p_key == epid_reg) ? idx_reg[PAW-1:0]
                                                          : free_at[PAW-1:0];
                    p_wdata  = {1'b1, epid_reg, now_reg};
                    idx_next = '0;
                    if (req_reg == REQ_WAKEUP)
                    begin
                        st_next    = ST_DONE;
                        state_next = S_RESP;
                    end
                    else if (npid_reg != '0)
                    begin
                        state_next = S_N_RD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (idx_reg == P_LAST)
                begin
                    st_next    = ST_PIDFULL;
                    state_next = S_RESP;
                end
                else
                begin
                    if (!p_v && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_P_RD;
                end
            end

            S_N_RD:
            begin
                state_next = S_N_CK;
            end

            S_N_CK:
            begin
                if (p_v && p_key == npid_reg)
                begin
                    // drop the entry and take the wait
                    p_we       = 1'b1;
                    wait_next  = now_reg - p_time;
                    bin_next   = '0;
                    state_next = S_LOG;
                end
                else if (idx_reg == P_LAST)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_N_RD;
                end
            end

            S_LOG:
            begin
                // a zero wait ends here too, at bucket zero
                if (wait_reg > TIME_W'(1))
                begin
                    wait_next = wait_reg >> 1;
                    bin_next  = bin_reg + 1'b1;
                end
                else
                begin
                    idx_next   = '0;
                    free_next  = 1'b0;
                    state_next = S_H_RD;
                end
            end

            S_H_RD:
            begin
                state_next = S_H_CK;
            end

            S_H_CK:
            begin
                free_any = free_reg || !h_v;
                if (h_v && h_grp == grp_reg && h_bin == bin_reg)
                begin
                    st_next = ST_DONE;
                    if (req_reg == REQ_READ)
                    begin
                        cnt_next = h_cnt;
                    end
                    else
                    begin
                        h_we     = 1'b1;
                        h_wdata  = {1'b1, grp_reg, bin_reg, h_cnt + 1'b1};
                        cnt_next = h_cnt + 1'b1;
                    end
                    state_next = S_RESP;
                end
                else if (idx_reg == H_LAST)
                begin
                    if (req_reg == REQ_READ)
                    begin
                        st_next = ST_NONE;
                    end
                    else if (free_any)
                    begin
                        h_we     = 1'b1;
                        h_waddr  = free_at[HAW-1:0];
                        h_wdata  = {1'b1, grp_reg, bin_reg, COUNT_W'(1)};
                        cnt_next = COUNT_W'(1);
                        st_next  = ST_DONE;
                    end
                    else
                    begin
                        st_next = ST_HISTFULL;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    if (!h_v && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_H_RD;
                end
            end

            S_RESP:
            begin
                // hold until the output register frees
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = st_reg;
                    out_bin_next   = bin_reg;
                    out_cnt_next   = cnt_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/rqlh_ram.sv]
// ----------------------------------------------------------------------------
// rqlh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rqlh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
